// ----- rtl/core/vec4_normalize_assert.svh -----
// Assertion macros used by the vector normalization top level
`ifndef VEC4_NORMALIZE_ASSERT_SVH
`define VEC4_NORMALIZE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset
`define V4N_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define V4N_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/v4n_pkg.sv -----
// Shared constants for the vector normalization pipeline
`default_nettype none
package v4n_pkg;
  // Normalized component: signed Q1.15
  localparam int UNIT_W = 16;
  localparam logic [UNIT_W-1:0] UNIT_MAX = 16'h7FFF;
  // Quotient of a^2 * 2^32 / sum, at most 2^32
  localparam int QUO_W = 33;
  // Root of that quotient
  localparam int QRT_W = (QUO_W + 1) / 2;
  // Cell stages in one component lane
  localparam int LANE_STAGES = QUO_W + QRT_W;
endpackage
`default_nettype wire

// ----- rtl/core/v4n_sqrt_cell.sv -----
// One restoring square-root step: resolves one root bit per cycle while en is high
`default_nettype none
module v4n_sqrt_cell #(
  parameter int RW     = 17,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              en,
  input  logic [2*RW-1:0]   rad_i,
  input  logic [RW:0]       rem_i,
  input  logic [RW-1:0]     root_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic [2*RW-1:0]   rad_o,
  output logic [RW:0]       rem_o,
  output logic [RW-1:0]     root_o,
  output logic [SIDE_W-1:0] side_o
);
  logic [RW+2:0] part;
  logic [RW+2:0] trial;
  logic [RW+2:0] diff;
  logic          fits;
  logic [2*RW-1:0]   rad_r;
  logic [RW:0]       rem_r;
  logic [RW-1:0]     root_r;
  logic [SIDE_W-1:0] side_r;

  // bring down the next two radicand bits and try root*4+1
  assign part  = {rem_i, rad_i[2*RW-1 -: 2]};
  assign trial = {1'b0, root_i, 2'b01};
  assign fits  = (part >= trial);
  assign diff  = part - trial;

  // advance one step
  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= {rad_i[2*RW-3:0], 2'b00};
      rem_r  <= fits ? diff[RW:0] : part[RW:0];
      root_r <= {root_i[RW-2:0], fits};
      side_r <= side_i;
    end
  end

  assign rad_o  = rad_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign side_o = side_r;
endmodule
`default_nettype wire

// ----- rtl/core/v4n_div_cell.sv -----
// One restoring division step: resolves one quotient bit per cycle while en is high
`default_nettype none
module v4n_div_cell #(
  parameter int SW = 33,
  parameter int QW = 33
) (
  input  logic          clk,
  input  logic          en,
  input  logic [SW-1:0] rem_i,
  input  logic [QW-1:0] num_i,
  input  logic [SW-1:0] dvs_i,
  input  logic [QW-1:0] quo_i,
  input  logic          sign_i,
  output logic [SW-1:0] rem_o,
  output logic [QW-1:0] num_o,
  output logic [SW-1:0] dvs_o,
  output logic [QW-1:0] quo_o,
  output logic          sign_o
);
  logic [SW:0]   part;
  logic [SW:0]   diff;
  logic          fits;
  logic [SW-1:0] rem_r;
  logic [QW-1:0] num_r;
  logic [SW-1:0] dvs_r;
  logic [QW-1:0] quo_r;
  logic          sign_r;

  // shift in the next numerator bit and try the divisor
  assign part = {rem_i, num_i[QW-1]};
  assign fits = (part >= {1'b0, dvs_i});
  assign diff = part - {1'b0, dvs_i};

  // advance one step
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= fits ? diff[SW-1:0] : part[SW-1:0];
      num_r  <= {num_i[QW-2:0], 1'b0};
      dvs_r  <= dvs_i;
      quo_r  <= {quo_i[QW-2:0], fits};
      sign_r <= sign_i;
    end
  end

  assign rem_o  = rem_r;
  assign num_o  = num_r;
  assign dvs_o  = dvs_r;
  assign quo_o  = quo_r;
  assign sign_o = sign_r;
endmodule
`default_nettype wire

// ----- rtl/core/v4n_lane.sv -----
// One component lane: a^2 * 2^32 / sum by a division row, then its root
`default_nettype none
module v4n_lane #(
  parameter int CW = 16
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [2*CW-2:0]           sq_i,
  input  logic                      sign_i,
  input  logic [2*CW:0]             sum_i,
  output logic [v4n_pkg::QRT_W-1:0] root_o,
  output logic                      sign_o
);
  localparam int SW  = 2 * CW + 1;
  localparam int QW  = v4n_pkg::QUO_W;
  localparam int RW  = v4n_pkg::QRT_W;
  localparam int A2W = 2 * CW - 1;

  logic [QW:0][SW-1:0] d_rem;
  logic [QW:0][QW-1:0] d_num;
  logic [QW:0][SW-1:0] d_dvs;
  logic [QW:0][QW-1:0] d_quo;
  logic [QW:0]         d_sgn;
  logic [RW:0][2*RW-1:0] s_rad;
  logic [RW:0][RW:0]     s_rem;
  logic [RW:0][RW-1:0]   s_root;
  logic [RW:0]           s_sgn;

  // start: partial remainder a^2 >> 1, then a^2[0] and zeros follow
  assign d_rem[0] = SW'(sq_i[A2W-1:1]);
  assign d_num[0] = {sq_i[0], {(QW-1){1'b0}}};
  assign d_dvs[0] = sum_i;
  assign d_quo[0] = '0;
  assign d_sgn[0] = sign_i;

  for (genvar k = 0; k < QW; k++) begin : g_div
    v4n_div_cell #(.SW(SW), .QW(QW)) u_cell (
      .clk(clk), .en(en),
      .rem_i(d_rem[k]), .num_i(d_num[k]), .dvs_i(d_dvs[k]),
      .quo_i(d_quo[k]), .sign_i(d_sgn[k]),
      .rem_o(d_rem[k+1]), .num_o(d_num[k+1]), .dvs_o(d_dvs[k+1]),
      .quo_o(d_quo[k+1]), .sign_o(d_sgn[k+1])
    );
  end

  // root of the quotient
  assign s_rad[0]  = (2*RW)'(d_quo[QW]);
  assign s_rem[0]  = '0;
  assign s_root[0] = '0;
  assign s_sgn[0]  = d_sgn[QW];

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    v4n_sqrt_cell #(.RW(RW), .SIDE_W(1)) u_cell (
      .clk(clk), .en(en),
      .rad_i(s_rad[k]), .rem_i(s_rem[k]), .root_i(s_root[k]), .side_i(s_sgn[k]),
      .rad_o(s_rad[k+1]), .rem_o(s_rem[k+1]), .root_o(s_root[k+1]), .side_o(s_sgn[k+1])
    );
  end

  assign root_o = s_root[RW];
  assign sign_o = s_sgn[RW];
endmodule
`default_nettype wire

// ----- rtl/core/vec4_normalize.sv -----
// Four-component vector normalization, top level
//
// Input channel in_*: one request per vector, components x, y, z, w as
// signed Q8.8 packed in in_tdata (x lowest). Output channel out_*: the four
// normalized components as signed Q1.15 (plus one saturates to 32767) and
// the length as unsigned Q9.8 in out_tdata, the zero-vector flag in out_tuser.
// A zero vector returns all zeros with the flag set.
// Throughput: one vector per cycle while out_tready does not hold the pipeline.
// Path: a squaring register and a summing register, then 33 division cells and
// 17 root cells per component lane, then one output register.
// The whole pipeline moves together: when the receiver holds out_tready low
// with a result waiting, every stage holds and in_tready falls; it rises
// again the cycle the result is taken. Reset empties the pipeline by clearing
// its valid bits; the data registers are not reset.
`default_nettype none
module vec4_normalize #(
  parameter int COMPONENT_WIDTH = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // comp_x, comp_y, comp_z, comp_w
  input  logic [((4*COMPONENT_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // unit_x, unit_y, unit_z, unit_w, magnitude
  output logic [((4*v4n_pkg::UNIT_W+COMPONENT_WIDTH+8)/8)*8-1:0] out_tdata,
  // zero_vector
  output logic out_tuser
);
  localparam int CW    = COMPONENT_WIDTH;
  localparam int UW    = v4n_pkg::UNIT_W;
  localparam int SW    = 2 * CW + 1;
  localparam int A2W   = 2 * CW - 1;
  localparam int RW    = CW + 1;
  localparam int QRW   = v4n_pkg::QRT_W;
  localparam int DLY   = v4n_pkg::LANE_STAGES - RW;
  localparam int NSTG  = v4n_pkg::LANE_STAGES + 3;
  localparam int OUT_W = ((4*UW + CW + 8) / 8) * 8;
  localparam int MAG_LO = 4 * UW;

  logic                en;
  logic [NSTG-1:0]     vld_r;
  logic [3:0][A2W-1:0] sq_s1_r;
  logic [3:0]          sgn_s1_r;
  logic [3:0][A2W-1:0] sq_s2_r;
  logic [3:0]          sgn_s2_r;
  logic [SW-1:0]       sum_r;
  logic [3:0][QRW-1:0] ln_root;
  logic [3:0]          ln_sgn;
  logic [RW:0][2*RW-1:0] m_rad;
  logic [RW:0][RW:0]     m_rem;
  logic [RW:0][RW-1:0]   m_root;
  logic [RW:0]           m_zero;
  logic [DLY-1:0][RW-1:0] dly_mag_r;
  logic [DLY-1:0]         dly_zero_r;
  logic [RW-1:0]          mag_round;
  logic [OUT_W-1:0]       out_data_r;
  logic [OUT_W-1:0]       out_data_nxt;
  logic                   out_zero_r;

  // advance everything unless a finished result is held
  assign en        = !vld_r[NSTG-1] || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-2:0], in_tvalid};
    end
  end

  // square each component magnitude, then sum
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        logic [CW-1:0]   c;
        logic [CW-1:0]   a;
        logic [2*CW-1:0] p;
        c = in_tdata[i*CW +: CW];
        a = c[CW-1] ? (~c + 1'b1) : c;
        p = a * a;
        sq_s1_r[i]  <= p[A2W-1:0];
        sgn_s1_r[i] <= c[CW-1];
      end
      sum_r    <= SW'(sq_s1_r[0]) + SW'(sq_s1_r[1]) + SW'(sq_s1_r[2]) + SW'(sq_s1_r[3]);
      sq_s2_r  <= sq_s1_r;
      sgn_s2_r <= sgn_s1_r;
    end
  end

  // one lane per component
  for (genvar i = 0; i < 4; i++) begin : g_lane
    v4n_lane #(.CW(CW)) u_lane (
      .clk(clk), .en(en),
      .sq_i(sq_s2_r[i]), .sign_i(sgn_s2_r[i]), .sum_i(sum_r),
      .root_o(ln_root[i]), .sign_o(ln_sgn[i])
    );
  end

  // length: root of the sum, zero flag rides along
  assign m_rad[0]  = (2*RW)'(sum_r);
  assign m_rem[0]  = '0;
  assign m_root[0] = '0;
  assign m_zero[0] = (sum_r == '0);

  for (genvar k = 0; k < RW; k++) begin : g_mag
    v4n_sqrt_cell #(.RW(RW), .SIDE_W(1)) u_cell (
      .clk(clk), .en(en),
      .rad_i(m_rad[k]), .rem_i(m_rem[k]), .root_i(m_root[k]), .side_i(m_zero[k]),
      .rad_o(m_rad[k+1]), .rem_o(m_rem[k+1]), .root_o(m_root[k+1]), .side_o(m_zero[k+1])
    );
  end

  // round to nearest, then hold until the lanes catch up
  assign mag_round = (m_rem[RW] > (RW+1)'(m_root[RW])) ? m_root[RW] + 1'b1 : m_root[RW];

  always_ff @(posedge clk) begin
    if (en) begin
      dly_mag_r[0]  <= mag_round;
      dly_zero_r[0] <= m_zero[RW];
      for (int k = 1; k < DLY; k++) begin
        dly_mag_r[k]  <= dly_mag_r[k-1];
        dly_zero_r[k] <= dly_zero_r[k-1];
      end
    end
  end

  // halve root+1 for round half up, saturate plus one, apply sign, clear for a zero vector
  always_comb begin
    logic [QRW:0]  inc;
    logic [UW-1:0] q;
    logic [UW-1:0] v;
    out_data_nxt = '0;
    for (int i = 0; i < 4; i++) begin
      inc = {1'b0, ln_root[i]} + 1'b1;
      q   = inc[UW:1];
      if (ln_sgn[i]) begin
        v = ~q + 1'b1;
      end else begin
        v = (q > v4n_pkg::UNIT_MAX) ? v4n_pkg::UNIT_MAX : q;
      end
      if (dly_zero_r[DLY-1]) begin
        v = '0;
      end
      out_data_nxt[i*UW +: UW] = v;
    end
    out_data_nxt[MAG_LO +: RW] = dly_mag_r[DLY-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
      out_zero_r <= dly_zero_r[DLY-1];
    end
  end

  assign out_tvalid = vld_r[NSTG-1];
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_zero_r;

  `include "vec4_normalize_assert.svh"

  `V4N_ASSERT_NOW(a_zero_clears, out_tvalid && out_tuser, out_tdata == '0, "zero vector with nonzero result")
  `V4N_ASSERT_NOW(a_len_nonzero, out_tvalid && !out_tuser, out_tdata[MAG_LO +: RW] != '0, "nonzero vector with zero length")
  `V4N_ASSERT_NOW(a_unit_nonzero, out_tvalid && !out_tuser, out_tdata[4*UW-1:0] != '0, "nonzero vector with all-zero unit")
  `V4N_ASSERT_NEXT(a_stall_holds, out_tvalid && !out_tready, vld_r[NSTG-1] && $stable(out_data_r), "held result changed")
endmodule
`default_nettype wire
